// ===== rtl/bbpe_pkg.sv =====
package bbpe_pkg;

  localparam int FRAC_BITS = 16;

  localparam int NUM_ENT = 16;
  localparam int IDX_W   = $clog2(NUM_ENT);
  localparam int CV_W    = 32;            // control value, point value
  localparam int CF_W    = 48;            // coefficient entry
  localparam int ACC_W   = 48;            // evaluation accumulators
  localparam int PRM_W   = 17;            // s, t and their powers

  // shared multiplier: 48-bit operands go through in two halves
  localparam int SPLIT = 24;
  localparam int MA_W  = SPLIT + 1;
  localparam int MB_W  = PRM_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int LO_W  = SPLIT + PRM_W;

  localparam int ROW_STEPS = 32;          // 16 row terms, two halves each
  localparam int MAC_STEPS = 40;          // plus 4 column terms
  localparam int CNT_W     = $clog2(MAC_STEPS);

  localparam logic [PRM_W-1:0] PRM_ONE = PRM_W'(2 ** FRAC_BITS);

  localparam logic signed [ACC_W-1:0] PV_MAX =
    {{(ACC_W-CV_W+1){1'b0}}, {(CV_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] PV_MIN = ~PV_MAX;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FORM = 2'd1,
    OP_EVAL = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_READ,
    FS_LAST,
    FS_WRITE
  } form_state_t;

  typedef enum logic [2:0] {
    ES_IDLE,
    ES_POW,
    ES_MAC,
    ES_DRAIN,
    ES_HOLD
  } eval_state_t;

  typedef logic signed [3:0] basis_t;

  localparam basis_t BASIS [4][4] = '{
    '{-4'sd1,  4'sd3, -4'sd3,  4'sd1},
    '{ 4'sd3, -4'sd6,  4'sd3,  4'sd0},
    '{-4'sd3,  4'sd3,  4'sd0,  4'sd0},
    '{ 4'sd1,  4'sd0,  4'sd0,  4'sd0}
  };

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] addr;
    logic [CV_W-1:0]  data;
  } ctrl_wr_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] addr;
    logic [CF_W-1:0]  data;
  } coef_wr_t;

  typedef struct packed {
    logic            done;
    logic [CV_W-1:0] point_value;
    logic            overflow;
  } eval_res_t;

  // v times a basis entry, by shifts and adds
  function automatic logic signed [CF_W-1:0] bz_scale(
    input logic signed [CF_W-1:0] v,
    input basis_t                 b
  );
    logic signed [CF_W-1:0] v3;
    logic signed [CF_W-1:0] res;
    v3 = v + (v <<< 1);
    case (b)
      4'sd1:   res = v;
      -4'sd1:  res = -v;
      4'sd3:   res = v3;
      -4'sd3:  res = -v3;
      -4'sd6:  res = -(v3 <<< 1);
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/bbpe_store.sv =====
module bbpe_store (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bbpe_pkg::ctrl_wr_t                  ctrl_wr,
  input  logic [bbpe_pkg::IDX_W-1:0]          ctrl_rd_addr,
  output logic signed [bbpe_pkg::CV_W-1:0]    ctrl_rd_data,
  input  bbpe_pkg::coef_wr_t                  coef_wr,
  input  logic [bbpe_pkg::IDX_W-1:0]          coef_rd_addr,
  output logic signed [bbpe_pkg::CF_W-1:0]    coef_rd_data
);

  logic [bbpe_pkg::CV_W-1:0] ctrl_mem [bbpe_pkg::NUM_ENT];
  logic [bbpe_pkg::CF_W-1:0] coef_mem [bbpe_pkg::NUM_ENT];

  logic [bbpe_pkg::NUM_ENT-1:0] ctrl_vld_r;
  logic [bbpe_pkg::NUM_ENT-1:0] coef_vld_r;

  logic [bbpe_pkg::CV_W-1:0] ctrl_q_r;
  logic [bbpe_pkg::CF_W-1:0] coef_q_r;
  logic                      ctrl_qv_r;
  logic                      coef_qv_r;

  always_ff @(posedge clk) begin
    if (ctrl_wr.wr_en) begin
      ctrl_mem[ctrl_wr.addr] <= ctrl_wr.data;
    end
    ctrl_q_r <= ctrl_mem[ctrl_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (coef_wr.wr_en) begin
      coef_mem[coef_wr.addr] <= coef_wr.data;
    end
    coef_q_r <= coef_mem[coef_rd_addr];
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_vld_r <= '0;
      coef_vld_r <= '0;
      ctrl_qv_r  <= 1'b0;
      coef_qv_r  <= 1'b0;
    end else begin
      if (ctrl_wr.wr_en) begin
        ctrl_vld_r[ctrl_wr.addr] <= 1'b1;
      end
      if (coef_wr.wr_en) begin
        coef_vld_r[coef_wr.addr] <= 1'b1;
      end
      ctrl_qv_r <= ctrl_vld_r[ctrl_rd_addr];
      coef_qv_r <= coef_vld_r[coef_rd_addr];
    end
  end

  assign ctrl_rd_data = ctrl_qv_r ? $signed(ctrl_q_r) : '0;
  assign coef_rd_data = coef_qv_r ? $signed(coef_q_r) : '0;

endmodule

// ===== rtl/bbpe_form.sv =====
module bbpe_form (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  output logic [bbpe_pkg::IDX_W-1:0]          ctrl_rd_addr,
  input  logic signed [bbpe_pkg::CV_W-1:0]    ctrl_rd_data,
  output logic [bbpe_pkg::IDX_W-1:0]          coef_rd_addr,
  input  logic signed [bbpe_pkg::CF_W-1:0]    coef_rd_data,
  output bbpe_pkg::coef_wr_t                  coef_wr
);

  // Pass 0: T = B*G, one column of G per group, T parked in the coefficient store.
  // Pass 1: C = T*B^T, one row of T per group, written back in place.
  // Both passes: acc[x] += B[x][k] * v[k], then acc[0..3] written out.

  bbpe_pkg::form_state_t state_r, state_nxt;

  logic [1:0] step_r;
  logic [1:0] grp_r;
  logic       pass_r;

  logic signed [bbpe_pkg::CF_W-1:0] acc_r [4];

  logic [1:0]                       k;
  logic                             acc_en;
  logic signed [bbpe_pkg::CF_W-1:0] v;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bbpe_pkg::FS_IDLE: begin
        if (start) state_nxt = bbpe_pkg::FS_READ;
      end
      bbpe_pkg::FS_READ: begin
        if (step_r == 2'd3) state_nxt = bbpe_pkg::FS_LAST;
      end
      bbpe_pkg::FS_LAST: begin
        state_nxt = bbpe_pkg::FS_WRITE;
      end
      bbpe_pkg::FS_WRITE: begin
        if (step_r == 2'd3) begin
          state_nxt = (pass_r && grp_r == 2'd3) ? bbpe_pkg::FS_IDLE : bbpe_pkg::FS_READ;
        end
      end
      default: state_nxt = bbpe_pkg::FS_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state_r != bbpe_pkg::FS_IDLE);
    // read data belongs to the address of the previous cycle
    k      = (state_r == bbpe_pkg::FS_LAST) ? 2'd3 : step_r - 2'd1;
    acc_en = (state_r == bbpe_pkg::FS_READ && step_r != 2'd0) ||
             (state_r == bbpe_pkg::FS_LAST);
    v      = pass_r ? coef_rd_data
                    : {{(bbpe_pkg::CF_W-bbpe_pkg::CV_W){ctrl_rd_data[bbpe_pkg::CV_W-1]}},
                       ctrl_rd_data};
    ctrl_rd_addr  = {step_r, grp_r};
    coef_rd_addr  = {grp_r, step_r};
    coef_wr.wr_en = (state_r == bbpe_pkg::FS_WRITE);
    coef_wr.addr  = pass_r ? {grp_r, step_r} : {step_r, grp_r};
    coef_wr.data  = acc_r[step_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bbpe_pkg::FS_IDLE;
      step_r  <= 2'd0;
      grp_r   <= 2'd0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == bbpe_pkg::FS_IDLE) begin
        step_r <= 2'd0;
        grp_r  <= 2'd0;
        pass_r <= 1'b0;
      end else if (state_r == bbpe_pkg::FS_READ) begin
        step_r <= step_r + 2'd1;
      end else if (state_r == bbpe_pkg::FS_WRITE) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          grp_r <= grp_r + 2'd1;
          if (grp_r == 2'd3) pass_r <= ~pass_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bbpe_pkg::FS_READ && step_r == 2'd0) begin
      for (int x = 0; x < 4; x++) acc_r[x] <= '0;
    end else if (acc_en) begin
      for (int x = 0; x < 4; x++) begin
        acc_r[x] <= acc_r[x] + bbpe_pkg::bz_scale(v, bbpe_pkg::BASIS[x][k]);
      end
    end
  end

endmodule

// ===== rtl/bbpe_eval.sv =====
module bbpe_eval (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [bbpe_pkg::PRM_W-1:0]          s_in,
  input  logic [bbpe_pkg::PRM_W-1:0]          t_in,
  input  logic                                out_free,
  output logic                                busy,
  output logic [bbpe_pkg::IDX_W-1:0]          coef_rd_addr,
  input  logic signed [bbpe_pkg::CF_W-1:0]    coef_rd_data,
  output bbpe_pkg::eval_res_t                 res
);

  // Step m of the MAC phase: m < 32 is row term C[i][j] (j = m[4:3], i = m[2:1]),
  // m >= 32 is column term u[j] (j = m[2:1]); m[0] picks the low or high half.
  // Pipeline: address -> multiply -> combine/accumulate.

  localparam int PW = bbpe_pkg::PRM_W;

  bbpe_pkg::eval_state_t state_r, state_nxt;

  logic [bbpe_pkg::CNT_W-1:0] cnt_r;
  logic [PW-1:0] s_r, t_r, s2_r, s3_r, t2_r, t3_r;
  logic          t3_pend_r;

  logic                       mv_r;
  logic [bbpe_pkg::CNT_W-1:0] mstep_r;
  logic                       pv_r;
  logic [bbpe_pkg::CNT_W-1:0] pstep_r;

  logic signed [bbpe_pkg::PROD_W-1:0] prod_r;
  logic [bbpe_pkg::LO_W-1:0]          lo_r;
  logic signed [bbpe_pkg::ACC_W-1:0]  u_r [4];
  logic signed [bbpe_pkg::ACC_W-1:0]  r_r;

  logic                              m_row;
  logic [1:0]                        sel;
  logic signed [bbpe_pkg::CF_W-1:0]  v_sel;
  logic [PW-1:0]                     p_sel;
  logic signed [bbpe_pkg::MA_W-1:0]  mul_a;
  logic signed [bbpe_pkg::MB_W-1:0]  mul_b;
  logic signed [bbpe_pkg::ACC_W-1:0] term;
  logic                              p_row;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bbpe_pkg::ES_IDLE: begin
        if (start) state_nxt = bbpe_pkg::ES_POW;
      end
      bbpe_pkg::ES_POW: begin
        if (cnt_r == bbpe_pkg::CNT_W'(3)) state_nxt = bbpe_pkg::ES_MAC;
      end
      bbpe_pkg::ES_MAC: begin
        if (cnt_r == bbpe_pkg::CNT_W'(bbpe_pkg::MAC_STEPS - 1)) state_nxt = bbpe_pkg::ES_DRAIN;
      end
      bbpe_pkg::ES_DRAIN: begin
        if (cnt_r == bbpe_pkg::CNT_W'(1)) state_nxt = bbpe_pkg::ES_HOLD;
      end
      bbpe_pkg::ES_HOLD: begin
        if (out_free) state_nxt = bbpe_pkg::ES_IDLE;
      end
      default: state_nxt = bbpe_pkg::ES_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state_r != bbpe_pkg::ES_IDLE);
    coef_rd_addr = {cnt_r[2:1], cnt_r[4:3]};

    m_row = (mstep_r < bbpe_pkg::CNT_W'(bbpe_pkg::ROW_STEPS));
    sel   = mstep_r[2:1];
    v_sel = m_row ? coef_rd_data : u_r[sel];
    case (sel)
      2'd0:    p_sel = m_row ? s3_r : t3_r;
      2'd1:    p_sel = m_row ? s2_r : t2_r;
      2'd2:    p_sel = m_row ? s_r  : t_r;
      default: p_sel = bbpe_pkg::PRM_ONE;
    endcase

    if (state_r == bbpe_pkg::ES_POW) begin
      case (cnt_r[1:0])
        2'd0:    begin mul_a = $signed(bbpe_pkg::MA_W'(s_r));  mul_b = $signed({1'b0, s_r}); end
        2'd1:    begin mul_a = $signed(bbpe_pkg::MA_W'(t_r));  mul_b = $signed({1'b0, t_r}); end
        2'd2:    begin mul_a = $signed(bbpe_pkg::MA_W'(s2_r)); mul_b = $signed({1'b0, s_r}); end
        default: begin mul_a = $signed(bbpe_pkg::MA_W'(t2_r)); mul_b = $signed({1'b0, t_r}); end
      endcase
    end else begin
      mul_a = mstep_r[0]
              ? {v_sel[bbpe_pkg::CF_W-1], v_sel[bbpe_pkg::CF_W-1:bbpe_pkg::SPLIT]}
              : $signed({1'b0, v_sel[bbpe_pkg::SPLIT-1:0]});
      mul_b = $signed({1'b0, p_sel});
    end

    // floor((hi*2^SPLIT + lo) / 2^FRAC) = hi*2^(SPLIT-FRAC) + floor(lo / 2^FRAC)
    p_row = (pstep_r < bbpe_pkg::CNT_W'(bbpe_pkg::ROW_STEPS));
    term  = (bbpe_pkg::ACC_W'(prod_r) <<< (bbpe_pkg::SPLIT - bbpe_pkg::FRAC_BITS)) +
            $signed(bbpe_pkg::ACC_W'(lo_r >> bbpe_pkg::FRAC_BITS));

    res.done = (state_r == bbpe_pkg::ES_HOLD) && out_free;
    if (r_r > bbpe_pkg::PV_MAX) begin
      res.point_value = bbpe_pkg::PV_MAX[bbpe_pkg::CV_W-1:0];
      res.overflow    = 1'b1;
    end else if (r_r < bbpe_pkg::PV_MIN) begin
      res.point_value = bbpe_pkg::PV_MIN[bbpe_pkg::CV_W-1:0];
      res.overflow    = 1'b1;
    end else begin
      res.point_value = r_r[bbpe_pkg::CV_W-1:0];
      res.overflow    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bbpe_pkg::ES_IDLE;
      cnt_r     <= '0;
      mv_r      <= 1'b0;
      pv_r      <= 1'b0;
      t3_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= (state_nxt != state_r) ? '0 : cnt_r + bbpe_pkg::CNT_W'(1);
      mv_r      <= (state_r == bbpe_pkg::ES_MAC);
      pv_r      <= mv_r;
      t3_pend_r <= (state_r == bbpe_pkg::ES_POW) && (cnt_r == bbpe_pkg::CNT_W'(3));
    end
  end

  always_ff @(posedge clk) begin
    mstep_r <= cnt_r;
    pstep_r <= mstep_r;
    prod_r  <= mul_a * mul_b;

    if (state_r == bbpe_pkg::ES_IDLE && start) begin
      s_r <= s_in;
      t_r <= t_in;
      r_r <= '0;
      for (int j = 0; j < 4; j++) u_r[j] <= '0;
    end

    // each power passes through prod_r before it lands in its register
    if (state_r == bbpe_pkg::ES_POW) begin
      case (cnt_r[1:0])
        2'd1:    s2_r <= prod_r[bbpe_pkg::FRAC_BITS +: PW];
        2'd2:    t2_r <= prod_r[bbpe_pkg::FRAC_BITS +: PW];
        2'd3:    s3_r <= prod_r[bbpe_pkg::FRAC_BITS +: PW];
        default: ;
      endcase
    end
    if (t3_pend_r) begin
      t3_r <= prod_r[bbpe_pkg::FRAC_BITS +: PW];
    end

    if (pv_r) begin
      if (!pstep_r[0]) begin
        lo_r <= prod_r[bbpe_pkg::LO_W-1:0];
      end else if (p_row) begin
        u_r[pstep_r[4:3]] <= u_r[pstep_r[4:3]] + term;
      end else begin
        r_r <= r_r + term;
      end
    end
  end

endmodule

// ===== rtl/bicubic_bezier_patch_eval.sv =====
// Channel  Ports                                                  Direction  Flow
// in       in_op, in_index, in_control_value, in_s_param, in_t_param  input  in_valid / in_stall
// out      out_point_value, out_overflow                          output     out_valid / out_stall
//
// Load (op 0) and op 3 (dropped) do not raise in_stall.
// Form (op 1) holds in_stall through 8 groups of 4 reads, 1 settle, 4 writes.
// Evaluate (op 2) raises out_valid after the one 25x18 multiplier has worked through its steps:
// 4 power products, 20 terms of two half-products each, the drain state, then the output reg.
// Reset clears both stores through per-entry valid bits; no sweep is needed.
// A result waits in the output register; a finished evaluation holds while it is full and stalled.
module bicubic_bezier_patch_eval (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_op,
  input  logic [bbpe_pkg::IDX_W-1:0]          in_index,
  input  logic signed [bbpe_pkg::CV_W-1:0]    in_control_value,
  input  logic [bbpe_pkg::PRM_W-1:0]          in_s_param,
  input  logic [bbpe_pkg::PRM_W-1:0]          in_t_param,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bbpe_pkg::CV_W-1:0]    out_point_value,
  output logic                                out_overflow
);

  logic accept;
  logic form_busy;
  logic eval_busy;
  logic form_start;
  logic eval_start;
  logic out_free;

  logic [bbpe_pkg::PRM_W-1:0] s_sat;
  logic [bbpe_pkg::PRM_W-1:0] t_sat;

  bbpe_pkg::ctrl_wr_t  ctrl_wr;
  bbpe_pkg::coef_wr_t  coef_wr;
  bbpe_pkg::eval_res_t eval_res;

  logic [bbpe_pkg::IDX_W-1:0]       ctrl_rd_addr;
  logic signed [bbpe_pkg::CV_W-1:0] ctrl_rd_data;
  logic [bbpe_pkg::IDX_W-1:0]       form_coef_addr;
  logic [bbpe_pkg::IDX_W-1:0]       eval_coef_addr;
  logic [bbpe_pkg::IDX_W-1:0]       coef_rd_addr;
  logic signed [bbpe_pkg::CF_W-1:0] coef_rd_data;

  logic                       out_valid_r;
  logic [bbpe_pkg::CV_W-1:0]  out_value_r;
  logic                       out_ovf_r;

  assign in_stall   = form_busy | eval_busy;
  assign accept     = in_valid & ~in_stall;
  assign form_start = accept && (in_op == bbpe_pkg::OP_FORM);
  assign eval_start = accept && (in_op == bbpe_pkg::OP_EVAL);
  assign out_free   = ~out_valid_r | ~out_stall;

  assign s_sat = (in_s_param > bbpe_pkg::PRM_ONE) ? bbpe_pkg::PRM_ONE : in_s_param;
  assign t_sat = (in_t_param > bbpe_pkg::PRM_ONE) ? bbpe_pkg::PRM_ONE : in_t_param;

  always_comb begin
    ctrl_wr.wr_en = accept && (in_op == bbpe_pkg::OP_LOAD);
    ctrl_wr.addr  = in_index;
    ctrl_wr.data  = in_control_value;
  end

  assign coef_rd_addr = eval_busy ? eval_coef_addr : form_coef_addr;

  bbpe_store u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl_wr      (ctrl_wr),
    .ctrl_rd_addr (ctrl_rd_addr),
    .ctrl_rd_data (ctrl_rd_data),
    .coef_wr      (coef_wr),
    .coef_rd_addr (coef_rd_addr),
    .coef_rd_data (coef_rd_data)
  );

  bbpe_form u_form (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (form_start),
    .busy         (form_busy),
    .ctrl_rd_addr (ctrl_rd_addr),
    .ctrl_rd_data (ctrl_rd_data),
    .coef_rd_addr (form_coef_addr),
    .coef_rd_data (coef_rd_data),
    .coef_wr      (coef_wr)
  );

  bbpe_eval u_eval (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (eval_start),
    .s_in         (s_sat),
    .t_in         (t_sat),
    .out_free     (out_free),
    .busy         (eval_busy),
    .coef_rd_addr (eval_coef_addr),
    .coef_rd_data (coef_rd_data),
    .res          (eval_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eval_res.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_res.done) begin
      out_value_r <= eval_res.point_value;
      out_ovf_r   <= eval_res.overflow;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_value = $signed(out_value_r);
  assign out_overflow    = out_ovf_r;

endmodule

// ===== bench/bicubic_bezier_patch_eval_chk.sv =====
`timescale 1ns / 1ps

module bicubic_bezier_patch_eval_chk (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [1:0]                       in_op,
  input  logic [bbpe_pkg::IDX_W-1:0]       in_index,
  input  logic signed [bbpe_pkg::CV_W-1:0] in_control_value,
  input  logic [bbpe_pkg::PRM_W-1:0]       in_s_param,
  input  logic [bbpe_pkg::PRM_W-1:0]       in_t_param,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [bbpe_pkg::CV_W-1:0] out_point_value,
  input  logic                             out_overflow,
  output int                               fail_count,
  output int                               pending
);
  import bbpe_pkg::*;

  localparam int BEZ [4][4] = '{
    '{-1,  3, -3, 1},
    '{ 3, -6,  3, 0},
    '{-3,  3,  0, 0},
    '{ 1,  0,  0, 0}
  };

  typedef struct {
    logic signed [CV_W-1:0] value;
    logic                   ovf;
  } point_t;

  point_t exp_points[$];
  point_t want;
  longint ctrl_pts[NUM_ENT];
  longint coef_mat[NUM_ENT];

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  // floor(v * p / 2^FRAC_BITS); fits in 64 bits for coefficient-sized v
  function automatic longint frac_mul(input longint v, input longint p);
    return (v * p) >>> FRAC_BITS;
  endfunction

  // C = B * G * B^T, exact
  function automatic void form_coef();
    longint part [4][4];
    longint acc;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += longint'(BEZ[i][k]) * ctrl_pts[k*4+j];
        part[i][j] = acc;
      end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += part[i][k] * longint'(BEZ[j][k]);
        coef_mat[i*4+j] = acc;
      end
  endfunction

  function automatic point_t eval_point(input logic [PRM_W-1:0] s_in,
                                        input logic [PRM_W-1:0] t_in);
    longint one;
    longint sp [4];
    longint tp [4];
    longint u;
    longint r;
    point_t res;
    one = longint'(1) << FRAC_BITS;
    // parameters above 1.0 clamp to 1.0
    sp[2] = (longint'(s_in) > one) ? one : longint'(s_in);
    tp[2] = (longint'(t_in) > one) ? one : longint'(t_in);
    sp[1] = (sp[2] * sp[2]) >>> FRAC_BITS;
    tp[1] = (tp[2] * tp[2]) >>> FRAC_BITS;
    sp[0] = (sp[1] * sp[2]) >>> FRAC_BITS;
    tp[0] = (tp[1] * tp[2]) >>> FRAC_BITS;
    sp[3] = one;
    tp[3] = one;
    r = 0;
    for (int j = 0; j < 4; j++) begin
      u = 0;
      for (int i = 0; i < 4; i++) u += frac_mul(coef_mat[i*4+j], sp[i]);
      r += frac_mul(u, tp[j]);
    end
    res.ovf = 1'b1;
    if (r > longint'(32'sh7FFFFFFF))       res.value = 32'sh7FFFFFFF;
    else if (r < -longint'(64'h80000000))  res.value = 32'sh80000000;
    else begin
      res.value = 32'(r);
      res.ovf   = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ENT; i++) begin
        ctrl_pts[i] = 0;
        coef_mat[i] = 0;
      end
      exp_points.delete();
      fail_count = 0;
    end else begin
      // result side first: a beat taken this edge predates any input of this edge
      if (out_valid && !out_stall) begin
        if (exp_points.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %h overflow %b",
                                    out_point_value, out_overflow));
        end else begin
          want = exp_points.pop_front();
          if (out_point_value !== want.value)
            report_mismatch($sformatf("point_value got %h want %h",
                                      out_point_value, want.value));
          if (out_overflow !== want.ovf)
            report_mismatch($sformatf("overflow got %b want %b (value %h)",
                                      out_overflow, want.ovf, want.value));
        end
      end
      if (in_valid && !in_stall) begin
        case (op_t'(in_op))
          OP_LOAD: ctrl_pts[in_index] = longint'(in_control_value);
          OP_FORM: form_coef();
          OP_EVAL: exp_points.push_back(eval_point(in_s_param, in_t_param));
          default: ;
        endcase
      end
    end
    pending = exp_points.size();
  end

endmodule

// ===== bench/bicubic_bezier_patch_eval_tb.sv =====
`timescale 1ns / 1ps

module bicubic_bezier_patch_eval_tb;
  import bbpe_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             in_op = OP_NOP;
  logic [IDX_W-1:0]       in_index = '0;
  logic signed [CV_W-1:0] in_control_value = '0;
  logic [PRM_W-1:0]       in_s_param = '0;
  logic [PRM_W-1:0]       in_t_param = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [CV_W-1:0] out_point_value;
  logic                   out_overflow;

  int fail_count;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  bicubic_bezier_patch_eval dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_op, .in_index, .in_control_value, .in_s_param, .in_t_param,
    .out_valid, .out_stall, .out_point_value, .out_overflow
  );

  bicubic_bezier_patch_eval_chk chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_op, .in_index, .in_control_value, .in_s_param, .in_t_param,
    .out_valid, .out_stall, .out_point_value, .out_overflow,
    .fail_count, .pending
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // one beat; returns just after the edge that took it
  task automatic send_beat(input op_t op, input logic [IDX_W-1:0] idx,
                           input logic [CV_W-1:0] cv,
                           input logic [PRM_W-1:0] s, input logic [PRM_W-1:0] t);
    bit took;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      if ($urandom_range(99) < 3) repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_index         <= idx;
    in_control_value <= cv;
    in_s_param       <= s;
    in_t_param       <= t;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    if (op != OP_NOP) sent++;
  endtask

  // hold off until every result owed has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [CV_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2:       return 32'($urandom_range(131072)) - 32'd65536;
      3:       return 32'($urandom_range(1 << 20)) - 32'd524288;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [PRM_W-1:0] pick_param();
    case ($urandom_range(9))
      0:       return '0;
      1:       return PRM_ONE;
      2:       return PRM_W'($urandom_range(65537, 131071));
      3:       return '1;
      default: return PRM_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic run_phase(input int in_idle, input int out_stall_pct, input int quota);
    int goal;
    int nld;
    int nev;
    goal      = sent + quota;
    idle_pct  = in_idle;
    stall_pct = out_stall_pct;
    while (sent < goal) begin
      if ($urandom_range(9) < 8) begin
        // a patch: control points, forming, a run of evaluations
        nld = ($urandom_range(3) == 0) ? $urandom_range(1, 15) : NUM_ENT;
        for (int k = 0; k < nld; k++)
          send_beat(OP_LOAD, (nld == NUM_ENT) ? IDX_W'(k) : IDX_W'($urandom_range(15)),
                    pick_value(), PRM_W'($urandom()), PRM_W'($urandom()));
        send_beat(OP_FORM, IDX_W'($urandom()), $urandom(), PRM_W'($urandom()),
                  PRM_W'($urandom()));
        nev = $urandom_range(2, 10);
        for (int k = 0; k < nev; k++)
          send_beat(OP_EVAL, IDX_W'($urandom()), $urandom(), pick_param(), pick_param());
      end else begin
        // noise: any op, any fields; evaluations may see stale coefficients
        repeat ($urandom_range(1, 4))
          send_beat(op_t'($urandom_range(3)), IDX_W'($urandom()), pick_value(),
                    pick_param(), pick_param());
      end
    end
  endtask

  initial begin
    int drain_wait;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // coefficients still clear from reset
    send_beat(OP_EVAL, '0, '0, PRM_ONE, PRM_ONE);
    send_beat(OP_NOP, '1, '1, '1, '1);
    // all control points at the negative limit: flooring can push below range
    for (int k = 0; k < NUM_ENT; k++)
      send_beat(OP_LOAD, IDX_W'(k), 32'h80000000, '0, '0);
    send_beat(OP_FORM, '0, '0, '0, '0);
    send_beat(OP_EVAL, '0, '0, '0, '0);
    send_beat(OP_EVAL, '0, '0, PRM_ONE, PRM_ONE);
    send_beat(OP_EVAL, '0, '0, '1, '1);
    send_beat(OP_EVAL, '0, '0, PRM_W'(32768), PRM_W'(98304));
    send_beat(OP_EVAL, '0, '0, PRM_W'(21845), PRM_W'(43690));
    // load without forming leaves the coefficients alone
    send_beat(OP_LOAD, '0, 32'h7FFFFFFF, '0, '0);
    send_beat(OP_EVAL, '0, '0, '0, '0);
    drain_results();

    run_phase(0, 0, 470);
    drain_results();
    run_phase(51, 0, 470);
    drain_results();
    run_phase(0, 51, 470);
    drain_results();
    run_phase(12, 12, 470);

    in_valid <= 1'b0;
    drain_wait = 0;
    @(negedge clk);
    while (pending != 0 && drain_wait < 20000) begin
      @(negedge clk);
      drain_wait++;
    end
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("bicubic_bezier_patch_eval regression: pass");
    end else begin
      $display("bicubic_bezier_patch_eval regression: fail");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("bicubic_bezier_patch_eval regression: fail");
    $finish;
  end

endmodule

// ===== bicubic_bezier_patch_eval.f =====
rtl/bbpe_pkg.sv
rtl/bbpe_store.sv
rtl/bbpe_form.sv
rtl/bbpe_eval.sv
rtl/bicubic_bezier_patch_eval.sv
bench/bicubic_bezier_patch_eval_chk.sv
bench/bicubic_bezier_patch_eval_tb.sv
